// File: hw/rtl/iw2d_pkg.sv
`timescale 1ns / 1ps

package iw2d_pkg;

    localparam int CMD_W   = 2;
    localparam int PIX_W   = 32;
    localparam int DIM_W   = 7;
    localparam int KER_W   = 4;
    localparam int NIB_W   = 4;
    localparam int CFG_W   = 8;
    localparam int IDX_W   = 4;
    localparam int CH_W    = 6;
    localparam int OUT_W   = 7;
    localparam int POS_W   = 6;
    localparam int SUM_W   = 11;
    localparam int CHH_W   = 12;
    localparam int ADDR_W  = 19;
    localparam int SPAN_W  = 8;
    localparam int ROOM_W  = 9;
    localparam int DIV_STEPS = 7;
    localparam int DCNT_W  = 3;

    localparam int MAX_SIDE   = 64;
    localparam int MAX_KERNEL = 15;

    typedef logic [CMD_W-1:0] cmd_t;
    localparam cmd_t CMD_LOAD    = 2'd0;
    localparam cmd_t CMD_EMIT    = 2'd1;
    localparam cmd_t CMD_RESTART = 2'd2;

    typedef logic [IDX_W-1:0] reg_idx_t;
    localparam reg_idx_t REG_CHANNELS = 4'd0;
    localparam reg_idx_t REG_HEIGHT   = 4'd1;
    localparam reg_idx_t REG_WIDTH    = 4'd2;
    localparam reg_idx_t REG_KHEIGHT  = 4'd3;
    localparam reg_idx_t REG_KWIDTH   = 4'd4;
    localparam reg_idx_t REG_PADDING  = 4'd5;
    localparam reg_idx_t REG_STRIDE   = 4'd6;
    localparam reg_idx_t REG_DILATION = 4'd7;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CALC,
        ST_ADDR,
        ST_DATA,
        ST_DIV,
        ST_LATCH
    } state_t;

    function automatic logic [DIM_W-1:0] clamp_side(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        if (v == '0)
            r = DIM_W'(1);
        else if (32'(v) > MAX_SIDE)
            r = DIM_W'(MAX_SIDE);
        else
            r = v;
        return r;
    endfunction

    function automatic logic [KER_W-1:0] clamp_kernel(input logic [KER_W-1:0] v);
        logic [KER_W-1:0] r;
        if (v == '0)
            r = KER_W'(1);
        else if (32'(v) > MAX_KERNEL)
            r = KER_W'(MAX_KERNEL);
        else
            r = v;
        return r;
    endfunction

    function automatic logic [NIB_W-1:0] nib_one(input logic [NIB_W-1:0] v);
        return (v == '0) ? NIB_W'(1) : v;
    endfunction

endpackage

// File: hw/rtl/iw2d_in_if.sv
`timescale 1ns / 1ps

interface iw2d_in_if;
    import iw2d_pkg::*;

    logic             valid;
    logic             ready;
    cmd_t             command;
    logic [PIX_W-1:0] pixel_value;

    modport source (output valid, output command, output pixel_value, input ready);
    modport sink   (input valid, input command, input pixel_value, output ready);
endinterface

// File: hw/rtl/iw2d_out_if.sv
`timescale 1ns / 1ps

interface iw2d_out_if;
    import iw2d_pkg::*;

    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] col_value;
    logic             last_of_matrix;
    logic             empty_geometry;

    modport source (output valid, output col_value, output last_of_matrix,
                    output empty_geometry, input ready);
    modport sink   (input valid, input col_value, input last_of_matrix,
                    input empty_geometry, output ready);
endinterface

// File: hw/rtl/iw2d_cfg_if.sv
`timescale 1ns / 1ps

interface iw2d_cfg_if;
    import iw2d_pkg::*;

    logic             valid;
    logic             ready;
    reg_idx_t         index;
    logic [CFG_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: hw/rtl/im2col_window_unfold_2d.sv
// channel  dir  word                                         handshake
// pix_ch   in   command, pixel_value                         valid/ready
// col_ch   out  col_value, last_of_matrix, empty_geometry    valid/ready
// cfg_ch   in   index, data (8 registers)                    valid/ready, ready always high
//
// Load and ignored commands keep the input ready. Emit steps through index math, address
// multiply and memory read, then the registered read word goes to the output register.
// Restart runs a 7-step restoring divider per side to set the output size.
// rst_n is asynchronous; no clearing pass, the image store is undefined until loaded.
// A stalled output holds its word; loads, restarts and the next emit's math still proceed.
`timescale 1ns / 1ps

module im2col_window_unfold_2d #(
    parameter int STORE_WORDS = 4096
) (
    input  logic        clk,
    input  logic        rst_n,
    iw2d_in_if.sink     pix_ch,
    iw2d_out_if.source  col_ch,
    iw2d_cfg_if.sink    cfg_ch
);
    import iw2d_pkg::*;

    localparam int AW = $clog2(STORE_WORDS);
    localparam int PW = $clog2(STORE_WORDS + 1);

    state_t state_reg, state_next;

    logic [DIM_W-1:0]  cfg_ch_reg, cfg_h_reg, cfg_w_reg;
    logic [KER_W-1:0]  cfg_kh_reg, cfg_kw_reg;
    logic [CFG_W-1:0]  cfg_pad_reg, cfg_st_reg, cfg_dil_reg;

    logic [PW-1:0]     ptr_reg, ptr_next;
    logic [CH_W-1:0]   ch_reg, ch_next;
    logic [KER_W-1:0]  kr_reg, kr_next, kc_reg, kc_next;
    logic [OUT_W-1:0]  or_reg, or_next, oc_reg, oc_next;
    logic [OUT_W-1:0]  oh_reg, oh_next, ow_reg, ow_next;
    logic [DCNT_W-1:0] dcnt_reg, dcnt_next;
    logic              out_valid_reg, out_valid_next;

    // payload
    logic [POS_W-1:0]  row_reg, row_next, col_reg, col_next;
    logic [CHH_W-1:0]  chh_reg, chh_next;
    logic              tap_ok_reg, tap_ok_next;
    logic              hit_reg, hit_next;
    logic              last_reg, last_next;
    logic              empty_reg, empty_next;
    logic [PIX_W-1:0]  val_out_reg, val_out_next;
    logic              last_out_reg, last_out_next;
    logic              empty_out_reg, empty_out_next;
    logic [OUT_W-1:0]  num_v_reg, num_v_next, num_h_reg, num_h_next;
    logic [NIB_W-1:0]  rem_v_reg, rem_v_next, rem_h_reg, rem_h_next;
    logic [NIB_W-1:0]  dst_v_reg, dst_v_next, dst_h_reg, dst_h_next;
    logic              neg_v_reg, neg_v_next, neg_h_reg, neg_h_next;

    logic [DIM_W-1:0]  c_c, h_c, w_c;
    logic [KER_W-1:0]  kh_c, kw_c;
    logic [NIB_W-1:0]  pad_v, pad_h, st_v, st_h, dil_v, dil_h;
    logic [SPAN_W-1:0] span_v, span_h;
    logic signed [ROOM_W-1:0] room_v, room_h;
    logic [SUM_W-1:0]  rsum, csum;
    logic signed [SUM_W:0] ir, ic;
    logic              at_oc, at_or, at_kc, at_kr, at_c;
    logic [ADDR_W-1:0] addr;
    logic [NIB_W:0]    tv, th;
    logic              ge_v, ge_h;
    logic [OUT_W-1:0]  q_v, q_h;

    logic              ram_we, ram_re;
    logic [PIX_W-1:0]  ram_rdata;

    assign c_c   = clamp_side(cfg_ch_reg);
    assign h_c   = clamp_side(cfg_h_reg);
    assign w_c   = clamp_side(cfg_w_reg);
    assign kh_c  = clamp_kernel(cfg_kh_reg);
    assign kw_c  = clamp_kernel(cfg_kw_reg);
    assign pad_v = cfg_pad_reg[7:4];
    assign pad_h = cfg_pad_reg[3:0];
    assign st_v  = nib_one(cfg_st_reg[7:4]);
    assign st_h  = nib_one(cfg_st_reg[3:0]);
    assign dil_v = nib_one(cfg_dil_reg[7:4]);
    assign dil_h = nib_one(cfg_dil_reg[3:0]);

    // room left for the dilated window in the padded image; negative means empty
    assign span_v = SPAN_W'(kh_c - KER_W'(1)) * SPAN_W'(dil_v) + SPAN_W'(1);
    assign span_h = SPAN_W'(kw_c - KER_W'(1)) * SPAN_W'(dil_h) + SPAN_W'(1);
    assign room_v = $signed(ROOM_W'(h_c)) + $signed(ROOM_W'({pad_v, 1'b0}))
                  - $signed({1'b0, span_v});
    assign room_h = $signed(ROOM_W'(w_c)) + $signed(ROOM_W'({pad_h, 1'b0}))
                  - $signed({1'b0, span_h});

    assign rsum = SUM_W'(kr_reg) * SUM_W'(dil_v) + SUM_W'(or_reg) * SUM_W'(st_v);
    assign csum = SUM_W'(kc_reg) * SUM_W'(dil_h) + SUM_W'(oc_reg) * SUM_W'(st_h);
    assign ir   = $signed({1'b0, rsum}) - $signed((SUM_W + 1)'(pad_v));
    assign ic   = $signed({1'b0, csum}) - $signed((SUM_W + 1)'(pad_h));

    assign at_oc = ({1'b0, oc_reg} + 8'd1) >= {1'b0, ow_reg};
    assign at_or = ({1'b0, or_reg} + 8'd1) >= {1'b0, oh_reg};
    assign at_kc = ({1'b0, kc_reg} + 5'd1) >= {1'b0, kw_c};
    assign at_kr = ({1'b0, kr_reg} + 5'd1) >= {1'b0, kh_c};
    assign at_c  = (DIM_W'(ch_reg) + DIM_W'(1)) >= c_c;

    assign addr = (ADDR_W'(chh_reg) + ADDR_W'(row_reg)) * ADDR_W'(w_c) + ADDR_W'(col_reg);

    // one restoring division step per side
    assign tv   = {rem_v_reg, num_v_reg[OUT_W-1]};
    assign th   = {rem_h_reg, num_h_reg[OUT_W-1]};
    assign ge_v = tv >= {1'b0, dst_v_reg};
    assign ge_h = th >= {1'b0, dst_h_reg};
    assign q_v  = neg_v_reg ? '0 : num_v_reg + OUT_W'(1);
    assign q_h  = neg_h_reg ? '0 : num_h_reg + OUT_W'(1);

    assign pix_ch.ready = (state_reg == ST_IDLE);
    assign cfg_ch.ready = 1'b1;

    assign col_ch.valid          = out_valid_reg;
    assign col_ch.col_value      = val_out_reg;
    assign col_ch.last_of_matrix = last_out_reg;
    assign col_ch.empty_geometry = empty_out_reg;

    iw2d_ram #(
        .WIDTH (PIX_W),
        .DEPTH (STORE_WORDS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ptr_reg[AW-1:0]),
        .wdata (pix_ch.pixel_value),
        .re    (ram_re),
        .raddr (addr[AW-1:0]),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        ptr_next       = ptr_reg;
        ch_next        = ch_reg;
        kr_next        = kr_reg;
        kc_next        = kc_reg;
        or_next        = or_reg;
        oc_next        = oc_reg;
        oh_next        = oh_reg;
        ow_next        = ow_reg;
        dcnt_next      = dcnt_reg;
        out_valid_next = out_valid_reg && !col_ch.ready;
        row_next       = row_reg;
        col_next       = col_reg;
        chh_next       = chh_reg;
        tap_ok_next    = tap_ok_reg;
        hit_next       = hit_reg;
        last_next      = last_reg;
        empty_next     = empty_reg;
        val_out_next   = val_out_reg;
        last_out_next  = last_out_reg;
        empty_out_next = empty_out_reg;
        num_v_next     = num_v_reg;
        num_h_next     = num_h_reg;
        rem_v_next     = rem_v_reg;
        rem_h_next     = rem_h_reg;
        dst_v_next     = dst_v_reg;
        dst_h_next     = dst_h_reg;
        neg_v_next     = neg_v_reg;
        neg_h_next     = neg_h_reg;
        ram_we         = 1'b0;
        ram_re         = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (pix_ch.valid)
                begin
                    unique case (pix_ch.command)
                        CMD_LOAD:
                        begin
                            // store full: word dropped, pointer parks
                            if (32'(ptr_reg) < STORE_WORDS)
                            begin
                                ram_we   = 1'b1;
                                ptr_next = ptr_reg + PW'(1);
                            end
                        end
                        CMD_EMIT:
                        begin
                            empty_next = (oh_reg == '0);
                            state_next = ST_CALC;
                        end
                        CMD_RESTART:
                        begin
                            ptr_next   = '0;
                            ch_next    = '0;
                            kr_next    = '0;
                            kc_next    = '0;
                            or_next    = '0;
                            oc_next    = '0;
                            neg_v_next = room_v[ROOM_W-1];
                            neg_h_next = room_h[ROOM_W-1];
                            num_v_next = room_v[OUT_W-1:0];
                            num_h_next = room_h[OUT_W-1:0];
                            rem_v_next = '0;
                            rem_h_next = '0;
                            dst_v_next = st_v;
                            dst_h_next = st_h;
                            dcnt_next  = '0;
                            state_next = ST_DIV;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_CALC:
            begin
                row_next    = ir[POS_W-1:0];
                col_next    = ic[POS_W-1:0];
                tap_ok_next = !ir[SUM_W] && (ir[SUM_W-1:0] < SUM_W'(h_c))
                           && !ic[SUM_W] && (ic[SUM_W-1:0] < SUM_W'(w_c));
                chh_next    = CHH_W'(ch_reg) * CHH_W'(h_c);
                last_next   = at_oc && at_or && at_kc && at_kr && at_c;
                if (!empty_reg)
                begin
                    if (!at_oc)
                    begin
                        oc_next = oc_reg + OUT_W'(1);
                    end
                    else
                    begin
                        oc_next = '0;
                        if (!at_or)
                        begin
                            or_next = or_reg + OUT_W'(1);
                        end
                        else
                        begin
                            or_next = '0;
                            if (!at_kc)
                            begin
                                kc_next = kc_reg + KER_W'(1);
                            end
                            else
                            begin
                                kc_next = '0;
                                if (!at_kr)
                                begin
                                    kr_next = kr_reg + KER_W'(1);
                                end
                                else
                                begin
                                    kr_next = '0;
                                    ch_next = at_c ? '0 : ch_reg + CH_W'(1);
                                end
                            end
                        end
                    end
                end
                state_next = ST_ADDR;
            end
            ST_ADDR:
            begin
                ram_re     = 1'b1;
                hit_next   = tap_ok_reg && (32'(addr) < STORE_WORDS);
                state_next = ST_DATA;
            end
            ST_DATA:
            begin
                if (!out_valid_reg || col_ch.ready)
                begin
                    out_valid_next = 1'b1;
                    val_out_next   = (hit_reg && !empty_reg) ? ram_rdata : '0;
                    last_out_next  = last_reg || empty_reg;
                    empty_out_next = empty_reg;
                    state_next     = ST_IDLE;
                end
            end
            ST_DIV:
            begin
                rem_v_next = ge_v ? NIB_W'(tv - {1'b0, dst_v_reg}) : tv[NIB_W-1:0];
                rem_h_next = ge_h ? NIB_W'(th - {1'b0, dst_h_reg}) : th[NIB_W-1:0];
                num_v_next = {num_v_reg[OUT_W-2:0], ge_v};
                num_h_next = {num_h_reg[OUT_W-2:0], ge_h};
                dcnt_next  = dcnt_reg + DCNT_W'(1);
                if (dcnt_reg == DCNT_W'(DIV_STEPS - 1))
                begin
                    state_next = ST_LATCH;
                end
            end
            ST_LATCH:
            begin
                if (q_v == '0 || q_h == '0)
                begin
                    oh_next = '0;
                    ow_next = '0;
                end
                else
                begin
                    oh_next = q_v;
                    ow_next = q_h;
                end
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cfg_ch_reg    <= DIM_W'(1);
            cfg_h_reg     <= DIM_W'(1);
            cfg_w_reg     <= DIM_W'(1);
            cfg_kh_reg    <= KER_W'(1);
            cfg_kw_reg    <= KER_W'(1);
            cfg_pad_reg   <= '0;
            cfg_st_reg    <= 8'h11;
            cfg_dil_reg   <= 8'h11;
            ptr_reg       <= '0;
            ch_reg        <= '0;
            kr_reg        <= '0;
            kc_reg        <= '0;
            or_reg        <= '0;
            oc_reg        <= '0;
            oh_reg        <= OUT_W'(1);
            ow_reg        <= OUT_W'(1);
            dcnt_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ptr_reg       <= ptr_next;
            ch_reg        <= ch_next;
            kr_reg        <= kr_next;
            kc_reg        <= kc_next;
            or_reg        <= or_next;
            oc_reg        <= oc_next;
            oh_reg        <= oh_next;
            ow_reg        <= ow_next;
            dcnt_reg      <= dcnt_next;
            out_valid_reg <= out_valid_next;
            if (cfg_ch.valid)
            begin
                unique case (cfg_ch.index)
                    REG_CHANNELS: cfg_ch_reg  <= cfg_ch.data[DIM_W-1:0];
                    REG_HEIGHT:   cfg_h_reg   <= cfg_ch.data[DIM_W-1:0];
                    REG_WIDTH:    cfg_w_reg   <= cfg_ch.data[DIM_W-1:0];
                    REG_KHEIGHT:  cfg_kh_reg  <= cfg_ch.data[KER_W-1:0];
                    REG_KWIDTH:   cfg_kw_reg  <= cfg_ch.data[KER_W-1:0];
                    REG_PADDING:  cfg_pad_reg <= cfg_ch.data;
                    REG_STRIDE:   cfg_st_reg  <= cfg_ch.data;
                    REG_DILATION: cfg_dil_reg <= cfg_ch.data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        row_reg       <= row_next;
        col_reg       <= col_next;
        chh_reg       <= chh_next;
        tap_ok_reg    <= tap_ok_next;
        hit_reg       <= hit_next;
        last_reg      <= last_next;
        empty_reg     <= empty_next;
        val_out_reg   <= val_out_next;
        last_out_reg  <= last_out_next;
        empty_out_reg <= empty_out_next;
        num_v_reg     <= num_v_next;
        num_h_reg     <= num_h_next;
        rem_v_reg     <= rem_v_next;
        rem_h_reg     <= rem_h_next;
        dst_v_reg     <= dst_v_next;
        dst_h_reg     <= dst_h_next;
        neg_v_reg     <= neg_v_next;
        neg_h_reg     <= neg_h_next;
    end
endmodule

// File: hw/rtl/iw2d_ram.sv
`timescale 1ns / 1ps

module iw2d_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

// File: hw/rtl/iw2d_checker.sv
`timescale 1ns / 1ps

module iw2d_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        pix_valid,
    input logic        pix_ready,
    input logic [1:0]  pix_command,
    input logic        col_valid,
    input logic        col_ready,
    input logic [31:0] col_value,
    input logic        col_last,
    input logic        col_empty
);
    import iw2d_pkg::*;

    // empty geometry word is always zero and closes the matrix
    a_empty_word: assert property (@(posedge clk) disable iff (!rst_n)
        col_valid && col_empty |-> col_last && (col_value == '0))
        else $error("empty geometry word malformed");

    a_emit_busy: assert property (@(posedge clk) disable iff (!rst_n)
        pix_valid && pix_ready && (pix_command == CMD_EMIT) |=> !pix_ready)
        else $error("emit accepted without going busy");

    a_restart_busy: assert property (@(posedge clk) disable iff (!rst_n)
        pix_valid && pix_ready && (pix_command == CMD_RESTART) |=> !pix_ready)
        else $error("restart accepted without size computation");

    a_load_single: assert property (@(posedge clk) disable iff (!rst_n)
        pix_valid && pix_ready && (pix_command == CMD_LOAD) |=> pix_ready)
        else $error("load word stalled the input");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        col_valid && !col_ready |=> col_valid && $stable(col_value)
                                    && $stable(col_last) && $stable(col_empty))
        else $error("stalled output word changed");
endmodule

bind im2col_window_unfold_2d iw2d_checker u_iw2d_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .pix_valid   (pix_ch.valid),
    .pix_ready   (pix_ch.ready),
    .pix_command (pix_ch.command),
    .col_valid   (col_ch.valid),
    .col_ready   (col_ch.ready),
    .col_value   (col_ch.col_value),
    .col_last    (col_ch.last_of_matrix),
    .col_empty   (col_ch.empty_geometry)
);

// File: bench/tb_im2col_window_unfold_2d.sv
`timescale 1ns / 1ps

module tb_im2col_window_unfold_2d;
    import iw2d_pkg::*;

    localparam int STORE_DEPTH  = 4096;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 16;
    localparam int HOLD_CYCLES  = 400;
    localparam int RANDOM_ITEMS = 1250;
    localparam int CALM_ITEMS   = 200;
    localparam int MAX_PRINTS   = 50;

    localparam cmd_t     CMD_UNUSED   = 2'd3;
    localparam reg_idx_t REG_SPARE_LO = 4'd8;
    localparam reg_idx_t REG_SPARE_HI = 4'd15;

    typedef struct packed {
        logic [PIX_W-1:0] col_value;
        logic             last_of_matrix;
        logic             empty_geometry;
    } col_word_t;

    class unfold_board;
        logic [PIX_W-1:0] image_mem [STORE_DEPTH];
        logic [CFG_W-1:0] regs [8];
        int unsigned      load_ptr;
        int unsigned      ch_i, kr_i, kc_i, or_i, oc_i;
        int unsigned      out_h, out_w;
        col_word_t        expected_cols [$];
        int               errors;
        int               n_cmds, n_cols, n_last, n_empty, n_dropped;

        function new();
            regs[REG_CHANNELS] = 8'd1;
            regs[REG_HEIGHT]   = 8'd1;
            regs[REG_WIDTH]    = 8'd1;
            regs[REG_KHEIGHT]  = 8'd1;
            regs[REG_KWIDTH]   = 8'd1;
            regs[REG_PADDING]  = 8'h00;
            regs[REG_STRIDE]   = 8'h11;
            regs[REG_DILATION] = 8'h11;
            clear_walk();
            latch_sizes();
        endfunction

        function int unsigned dim_of(reg_idx_t idx, int unsigned hi);
            int unsigned v;
            v = regs[idx];
            if (v == 0)
                v = 1;
            else if (v > hi)
                v = hi;
            return v;
        endfunction

        function int unsigned nib_or_one(logic [NIB_W-1:0] v);
            return (v == 0) ? 1 : v;
        endfunction

        function int unsigned side_len(int unsigned img, int unsigned pad, int unsigned k,
                                       int unsigned dil, int unsigned st);
            int room;
            room = int'(img + 2 * pad) - int'(dil * (k - 1) + 1);
            if (room < 0)
                return 0;
            return room / st + 1;
        endfunction

        function void latch_sizes();
            out_h = side_len(dim_of(REG_HEIGHT, MAX_SIDE), regs[REG_PADDING][7:4],
                             dim_of(REG_KHEIGHT, MAX_KERNEL),
                             nib_or_one(regs[REG_DILATION][7:4]),
                             nib_or_one(regs[REG_STRIDE][7:4]));
            out_w = side_len(dim_of(REG_WIDTH, MAX_SIDE), regs[REG_PADDING][3:0],
                             dim_of(REG_KWIDTH, MAX_KERNEL),
                             nib_or_one(regs[REG_DILATION][3:0]),
                             nib_or_one(regs[REG_STRIDE][3:0]));
            if (out_h == 0 || out_w == 0)
            begin
                out_h = 0;
                out_w = 0;
            end
        endfunction

        function void clear_walk();
            load_ptr = 0;
            ch_i = 0;
            kr_i = 0;
            kc_i = 0;
            or_i = 0;
            oc_i = 0;
        endfunction

        function void apply_reg(reg_idx_t idx, logic [CFG_W-1:0] data);
            case (idx)
                REG_CHANNELS, REG_HEIGHT, REG_WIDTH: regs[idx] = {1'b0, data[6:0]};
                REG_KHEIGHT, REG_KWIDTH:             regs[idx] = {4'b0, data[3:0]};
                REG_PADDING, REG_STRIDE, REG_DILATION: regs[idx] = data;
                default: ;
            endcase
        endfunction

        function int unsigned image_words();
            int unsigned n;
            n = dim_of(REG_CHANNELS, MAX_SIDE) * dim_of(REG_HEIGHT, MAX_SIDE)
                * dim_of(REG_WIDTH, MAX_SIDE);
            return (n > STORE_DEPTH) ? STORE_DEPTH : n;
        endfunction

        function int unsigned matrix_len();
            return dim_of(REG_CHANNELS, MAX_SIDE) * dim_of(REG_KHEIGHT, MAX_KERNEL)
                   * dim_of(REG_KWIDTH, MAX_KERNEL) * out_h * out_w;
        endfunction

        function void note_command(cmd_t cmd, logic [PIX_W-1:0] pix);
            col_word_t   w;
            int unsigned c, h, wd, kh, kw, addr;
            int          ir, ic;
            bit          at_c, at_kr, at_kc, at_or, at_oc;
            n_cmds++;
            if (cmd == CMD_LOAD)
            begin
                if (load_ptr < STORE_DEPTH)
                begin
                    image_mem[load_ptr] = pix;
                    load_ptr++;
                end
                else
                    n_dropped++;
            end
            else if (cmd == CMD_RESTART)
            begin
                clear_walk();
                latch_sizes();
            end
            else if (cmd == CMD_EMIT)
            begin
                if (out_h == 0 || out_w == 0)
                begin
                    // empty output: flagged, walk stays put
                    w.col_value      = '0;
                    w.last_of_matrix = 1'b1;
                    w.empty_geometry = 1'b1;
                end
                else
                begin
                    c  = dim_of(REG_CHANNELS, MAX_SIDE);
                    h  = dim_of(REG_HEIGHT, MAX_SIDE);
                    wd = dim_of(REG_WIDTH, MAX_SIDE);
                    kh = dim_of(REG_KHEIGHT, MAX_KERNEL);
                    kw = dim_of(REG_KWIDTH, MAX_KERNEL);
                    ir = int'(kr_i * nib_or_one(regs[REG_DILATION][7:4])
                              + or_i * nib_or_one(regs[REG_STRIDE][7:4]))
                         - int'(regs[REG_PADDING][7:4]);
                    ic = int'(kc_i * nib_or_one(regs[REG_DILATION][3:0])
                              + oc_i * nib_or_one(regs[REG_STRIDE][3:0]))
                         - int'(regs[REG_PADDING][3:0]);
                    w.col_value = '0;
                    if (ir >= 0 && ir < int'(h) && ic >= 0 && ic < int'(wd))
                    begin
                        addr = (ch_i * h + int'(ir)) * wd + int'(ic);
                        if (addr < STORE_DEPTH)
                            w.col_value = image_mem[addr];
                    end
                    // counters past a shrunken limit count as at their last value
                    at_oc = oc_i + 1 >= out_w;
                    at_or = or_i + 1 >= out_h;
                    at_kc = kc_i + 1 >= kw;
                    at_kr = kr_i + 1 >= kh;
                    at_c  = ch_i + 1 >= c;
                    w.last_of_matrix = at_oc && at_or && at_kc && at_kr && at_c;
                    w.empty_geometry = 1'b0;
                    if (!at_oc)
                        oc_i++;
                    else
                    begin
                        oc_i = 0;
                        if (!at_or)
                            or_i++;
                        else
                        begin
                            or_i = 0;
                            if (!at_kc)
                                kc_i++;
                            else
                            begin
                                kc_i = 0;
                                if (!at_kr)
                                    kr_i++;
                                else
                                begin
                                    kr_i = 0;
                                    ch_i = at_c ? 0 : ch_i + 1;
                                end
                            end
                        end
                    end
                end
                expected_cols.push_back(w);
            end
        endfunction

        task flag(string msg);
            if (errors < MAX_PRINTS)
                $display("MISMATCH at %0t ns: %s", $time, msg);
            errors++;
        endtask

        task check_col(col_word_t got);
            col_word_t want;
            n_cols++;
            if (got.last_of_matrix)
                n_last++;
            if (got.empty_geometry)
                n_empty++;
            if (expected_cols.size() == 0)
            begin
                flag($sformatf("column word %0d arrived with nothing expected", n_cols));
                return;
            end
            want = expected_cols.pop_front();
            if (got.col_value !== want.col_value)
                flag($sformatf("word %0d col_value %h, expected %h",
                               n_cols, got.col_value, want.col_value));
            if (got.last_of_matrix !== want.last_of_matrix)
                flag($sformatf("word %0d last_of_matrix %b, expected %b",
                               n_cols, got.last_of_matrix, want.last_of_matrix));
            if (got.empty_geometry !== want.empty_geometry)
                flag($sformatf("word %0d empty_geometry %b, expected %b",
                               n_cols, got.empty_geometry, want.empty_geometry));
        endtask
    endclass

    logic clk;
    logic rst_n;

    iw2d_in_if  pix_ch ();
    iw2d_out_if col_ch ();
    iw2d_cfg_if cfg_ch ();

    im2col_window_unfold_2d #(.STORE_WORDS(STORE_DEPTH)) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .pix_ch (pix_ch),
        .col_ch (col_ch),
        .cfg_ch (cfg_ch)
    );

    unfold_board board;
    bit          calm;
    int          idle_mode;
    int          hold_asked;
    int          hold_given;
    int          hold_left;
    int          stall_left;
    int          cycles;
    int          geometries;

    initial clk = 1'b0;
    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("run stopped after %0d cycles", cycles);
            $display("FAIL im2col_window_unfold_2d");
            $finish;
        end
    end

    // result side: check accepted words, random stalls, one long hold-off on request
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (col_ch.valid && col_ch.ready)
                board.check_col({col_ch.col_value, col_ch.last_of_matrix,
                                 col_ch.empty_geometry});
            if (hold_given < hold_asked)
            begin
                hold_given++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                col_ch.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                col_ch.ready <= 1'b0;
            end
            else if (idle_mode != 0 && $urandom_range(idle_mode == 1 ? 15 : 4, 0) == 0)
            begin
                stall_left = $urandom_range(12, 0);
                col_ch.ready <= 1'b0;
            end
            else
                col_ch.ready <= 1'b1;
        end
    end

    function automatic logic [PIX_W-1:0] rand_pixel();
        logic [PIX_W-1:0] v;
        case ($urandom_range(9, 0))
            0: v = '0;
            1: v = '1;
            2: v = 32'h8000_0000;
            3: v = 32'h3F80_0000;
            default: v = $urandom;
        endcase
        return v;
    endfunction

    task automatic pick_idling();
        idle_mode = calm ? 0 : $urandom_range(2, 0);
    endtask

    task automatic send(cmd_t cmd, logic [PIX_W-1:0] pix);
        pix_ch.valid       <= 1'b1;
        pix_ch.command     <= cmd;
        pix_ch.pixel_value <= pix;
        do
            @(posedge clk);
        while (!pix_ch.ready);
        board.note_command(cmd, pix);
        if (idle_mode != 0 && $urandom_range(idle_mode == 1 ? 15 : 4, 0) == 0)
        begin
            pix_ch.valid <= 1'b0;
            repeat ($urandom_range(13, 1)) @(posedge clk);
        end
    endtask

    task automatic write_reg(reg_idx_t idx, logic [CFG_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        board.apply_reg(idx, data);
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    // stop offering, wait out every pending word, then the restart latency
    task automatic drain();
        pix_ch.valid <= 1'b0;
        while (board.expected_cols.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_geometry(logic [CFG_W-1:0] c, h, w, kh, kw, pad, str, dil);
        drain();
        write_reg(REG_CHANNELS, c);
        write_reg(REG_HEIGHT, h);
        write_reg(REG_WIDTH, w);
        write_reg(REG_KHEIGHT, kh);
        write_reg(REG_KWIDTH, kw);
        write_reg(REG_PADDING, pad);
        write_reg(REG_STRIDE, str);
        write_reg(REG_DILATION, dil);
        if ($urandom_range(3, 0) == 0)
            write_reg(reg_idx_t'($urandom_range(REG_SPARE_HI, REG_SPARE_LO)), 8'($urandom));
        geometries++;
    endtask

    task automatic load_image();
        int unsigned n;
        n = board.image_words();
        repeat (n) send(CMD_LOAD, rand_pixel());
    endtask

    task automatic emit_words(int n);
        repeat (n) send(CMD_EMIT, $urandom);
    endtask

    task automatic random_phase();
        int unsigned len;
        int          n_emit;
        pick_idling();
        set_geometry(8'($urandom_range(3, 1)), 8'($urandom_range(8, 1)),
                     8'($urandom_range(8, 1)), 8'($urandom_range(4, 1)),
                     8'($urandom_range(4, 1)),
                     {4'($urandom_range(2, 0)), 4'($urandom_range(2, 0))},
                     {4'($urandom_range(3, 0)), 4'($urandom_range(3, 0))},
                     {4'($urandom_range(2, 0)), 4'($urandom_range(2, 0))});
        send(CMD_RESTART, $urandom);
        if ($urandom_range(3, 0) != 0)
            load_image();
        len = board.matrix_len();
        if (len == 0)
            n_emit = 3;
        else if (len > 120)
            n_emit = $urandom_range(120, 20);
        else
            n_emit = len + $urandom_range(4, 0);
        for (int k = 0; k < n_emit; k++)
        begin
            if (k == n_emit / 2 && $urandom_range(3, 0) == 0)
                drain();
            case ($urandom_range(39, 0))
                0: send(CMD_LOAD, rand_pixel());
                1: send(CMD_UNUSED, $urandom);
                2: send(CMD_RESTART, $urandom);
                default: send(CMD_EMIT, $urandom);
            endcase
        end
        // resize mid-walk without a restart
        if ($urandom_range(4, 0) == 0)
        begin
            drain();
            write_reg(reg_idx_t'($urandom_range(REG_KWIDTH, REG_CHANNELS)),
                      8'($urandom_range(6, 0)));
            emit_words($urandom_range(12, 2));
        end
    endtask

    initial
    begin
        int start_cmds;
        board = new();
        calm       = 1'b0;
        idle_mode  = 0;
        hold_asked = 0;
        hold_given = 0;
        hold_left  = 0;
        stall_left = 0;
        cycles     = 0;
        geometries = 0;
        pix_ch.valid       = 1'b0;
        pix_ch.command     = CMD_LOAD;
        pix_ch.pixel_value = '0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.index       = REG_CHANNELS;
        cfg_ch.data        = '0;
        col_ch.ready       = 1'b0;
        rst_n              = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset geometry: one pixel, one tap, every word ends the matrix
        send(CMD_LOAD, '1);
        send(CMD_EMIT, $urandom);
        send(CMD_LOAD, '0);
        send(CMD_EMIT, $urandom);
        send(CMD_UNUSED, $urandom);

        // fill the whole store and overrun it; channel 1 sits above the store
        pick_idling();
        set_geometry(8'd2, 8'd64, 8'd64, 8'd1, 8'd1, 8'h00, 8'hFF, 8'h00);
        send(CMD_RESTART, $urandom);
        repeat (STORE_DEPTH + 4) send(CMD_LOAD, rand_pixel());
        emit_words(53);

        // window larger than the image on both sides
        set_geometry(8'd64, 8'd1, 8'd1, 8'd15, 8'd15, 8'h00, 8'h11, 8'h11);
        send(CMD_RESTART, $urandom);
        emit_words(2);

        // only the width side is empty
        set_geometry(8'd1, 8'd8, 8'd2, 8'd1, 8'd15, 8'h00, 8'h00, 8'h00);
        send(CMD_RESTART, $urandom);
        emit_words(2);

        // masked and saturated sizes, full padding and stride
        set_geometry(8'd100, 8'hFF, 8'h80, 8'hF0, 8'h0F, 8'hFF, 8'hFF, 8'hF1);
        send(CMD_RESTART, $urandom);
        emit_words(10);

        // shrink sizes mid-walk, no restart
        drain();
        write_reg(REG_CHANNELS, 8'd1);
        write_reg(REG_KWIDTH, 8'd3);
        write_reg(REG_HEIGHT, 8'd5);
        emit_words(8);

        // small padded matrix with pixel extremes, run past the wrap
        set_geometry(8'd1, 8'd1, 8'd2, 8'd1, 8'd2, 8'h01, 8'h00, 8'h00);
        send(CMD_RESTART, $urandom);
        send(CMD_LOAD, '0);
        send(CMD_LOAD, '1);
        emit_words(8);

        // long hold-off on the result side while words keep coming
        idle_mode = 0;
        set_geometry(8'd2, 8'd4, 8'd4, 8'd3, 8'd3, 8'h11, 8'h11, 8'h11);
        send(CMD_RESTART, $urandom);
        load_image();
        hold_asked++;
        emit_words(60);
        drain();

        start_cmds = board.n_cmds;
        while (board.n_cmds - start_cmds < RANDOM_ITEMS)
        begin
            if (board.n_cmds - start_cmds > RANDOM_ITEMS - CALM_ITEMS)
                calm = 1'b1;
            random_phase();
        end

        drain();
        $display("covered %0d commands over %0d geometries, %0d loads dropped at full store",
                 board.n_cmds, geometries, board.n_dropped);
        $display("checked %0d column words: %0d matrix ends, %0d empty geometry, %0d errors",
                 board.n_cols, board.n_last, board.n_empty, board.errors);
        if (board.errors == 0)
            $display("PASS im2col_window_unfold_2d");
        else
            $display("FAIL im2col_window_unfold_2d");
        $finish;
    end

endmodule
